FILE: hdl/rbm_pkg.sv
// ----------------------------------------------------------------------------
// rbm_pkg: shared types and constants for the brake merger
// Holds the transaction payload types, the register set, register indexes,
// the sequencer states and the divide-by-neutral helper.
// ----------------------------------------------------------------------------
package rbm_pkg;

  localparam logic [14:0] NEUTRAL     = 15'd32767;
  localparam logic [23:0] RECIP_100   = 24'd10737419;
  localparam int          RECIP_SHIFT = 30;

  localparam logic [2:0] REG_REV_PCT   = 3'd0;
  localparam logic [2:0] REG_HOLD_MS   = 3'd1;
  localparam logic [2:0] REG_DEAD_BAND = 3'd2;
  localparam logic [2:0] REG_MAX_BRAKE = 3'd3;
  localparam logic [2:0] REG_BRK_PCT   = 3'd4;
  localparam logic [2:0] REG_MAX_STEP  = 3'd5;
  localparam logic [2:0] REG_LINK_EN   = 3'd6;

  typedef struct packed {
    logic [15:0] brake_raw;
    logic [15:0] ramp_value;
    logic [15:0] stick_value;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [14:0] brake_out;
    logic [15:0] ramp_brake_steps;
    logic        steps_valid;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  rev_brake_scale_pct;
    logic [15:0] reverse_hold_ms;
    logic [14:0] rev_brake_dead_band;
    logic [14:0] max_brake;
    logic [6:0]  brake_scale_pct;
    logic [15:0] max_brake_step;
    logic        ramp_link_enable;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SQ,
    ST_DIV_SQ,
    ST_MUL_BS,
    ST_REC_BS,
    ST_MUL_DV,
    ST_REC_DV,
    ST_REV,
    ST_MERGE,
    ST_HOLD,
    ST_MUL_ST,
    ST_DONE
  } seq_state_t;

  // Quotient of x by NEUTRAL, using 2^15 = NEUTRAL + 1; exact while x[30:15] + x[14:0] is below three times NEUTRAL.
  function automatic logic [16:0] div_neutral(input logic [30:0] x);
    logic [15:0] q0;
    logic [16:0] r;
    logic [1:0]  corr;
    q0 = x[30:15];
    r = {2'b00, x[14:0]} + {1'b0, q0};
    if (r >= {1'b0, NEUTRAL, 1'b0}) begin
      corr = 2'd2;
    end else if (r >= {2'b00, NEUTRAL}) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
    return {1'b0, q0} + {15'd0, corr};
  endfunction

endpackage

FILE: hdl/rbm_cfg_regs.sv
// ----------------------------------------------------------------------------
// rbm_cfg_regs: configuration register file
// Captures register writes from the configuration channel; unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
module rbm_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [15:0]       wr_data,
  output rbm_pkg::cfg_regs_t cfg
);

  rbm_pkg::cfg_regs_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        rbm_pkg::REG_REV_PCT:   cfg_nxt.rev_brake_scale_pct = wr_data[7:0];
        rbm_pkg::REG_HOLD_MS:   cfg_nxt.reverse_hold_ms     = wr_data;
        rbm_pkg::REG_DEAD_BAND: cfg_nxt.rev_brake_dead_band = wr_data[14:0];
        rbm_pkg::REG_MAX_BRAKE: cfg_nxt.max_brake           = wr_data[14:0];
        rbm_pkg::REG_BRK_PCT:   cfg_nxt.brake_scale_pct     = wr_data[6:0];
        rbm_pkg::REG_MAX_STEP:  cfg_nxt.max_brake_step      = wr_data;
        rbm_pkg::REG_LINK_EN:   cfg_nxt.ramp_link_enable    = wr_data[0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rev_brake_scale_pct <= 8'd100;
      cfg_r.reverse_hold_ms     <= 16'd500;
      cfg_r.rev_brake_dead_band <= 15'd0;
      cfg_r.max_brake           <= 15'd32767;
      cfg_r.brake_scale_pct     <= 7'd100;
      cfg_r.max_brake_step      <= 16'd0;
      cfg_r.ramp_link_enable    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/rbm_mul_unit.sv
// ----------------------------------------------------------------------------
// rbm_mul_unit: shared multiplier
// One unsigned 24 by 24 multiplier with a registered product, reused by every
// multiply step of the sequencer.
// ----------------------------------------------------------------------------
module rbm_mul_unit (
  input  logic        clk,
  input  logic        en,
  input  logic [23:0] op_a,
  input  logic [23:0] op_b,
  output logic [47:0] prod
);

  logic [47:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule

FILE: hdl/rbm_seq.sv
// ----------------------------------------------------------------------------
// rbm_seq: sequencer and datapath
// Steps one transaction through the shared multiplier, the constant divides,
// the reverse-hold state update and the merge.
// ----------------------------------------------------------------------------
module rbm_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  rbm_pkg::cfg_regs_t  cfg,
  input  logic                start,
  input  rbm_pkg::in_item_t   item,
  output logic                idle,
  output logic                res_valid,
  input  logic                res_take,
  output rbm_pkg::out_item_t  res
);

  rbm_pkg::seq_state_t state_r, state_nxt;

  logic [14:0] half_r, half_nxt;
  logic [31:0] now_r, now_nxt;
  logic [15:0] dev_r, dev_nxt;
  logic [16:0] sq_r, sq_nxt;
  logic [15:0] sb_r, sb_nxt;
  logic [14:0] rev_r, rev_nxt;
  logic [14:0] fin_r, fin_nxt;
  logic        rev_act_r, rev_act_nxt;
  logic [31:0] deadline_r, deadline_nxt;

  logic        mul_en;
  logic [23:0] mul_a, mul_b;
  logic [47:0] prod;

  logic [15:0] dev_in;
  logic [16:0] rev_q;
  logic        rev_end;
  logic [15:0] top_src;
  logic [16:0] steps_q;

  rbm_mul_unit u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  always_comb begin
    dev_in = 16'd0;
    if (item.ramp_value > {1'b0, rbm_pkg::NEUTRAL} &&
        item.stick_value < {1'b0, rbm_pkg::NEUTRAL}) begin
      dev_in = {1'b0, rbm_pkg::NEUTRAL} - item.stick_value;
    end else if (item.ramp_value < {1'b0, rbm_pkg::NEUTRAL} &&
                 item.stick_value > {1'b0, rbm_pkg::NEUTRAL}) begin
      dev_in = item.stick_value - {1'b0, rbm_pkg::NEUTRAL};
    end
  end

  assign rev_q   = prod[46:30];
  assign rev_end = rev_act_r && (rev_r == 15'd0);
  assign top_src = (sb_r > {1'b0, rev_r}) ? sb_r : {1'b0, rev_r};
  assign steps_q = rbm_pkg::div_neutral(prod[30:0]);

  always_comb begin
    state_nxt    = state_r;
    half_nxt     = half_r;
    now_nxt      = now_r;
    dev_nxt      = dev_r;
    sq_nxt       = sq_r;
    sb_nxt       = sb_r;
    rev_nxt      = rev_r;
    fin_nxt      = fin_r;
    rev_act_nxt  = rev_act_r;
    deadline_nxt = deadline_r;
    mul_en       = 1'b0;
    mul_a        = 24'd0;
    mul_b        = 24'd0;
    unique case (state_r)
      rbm_pkg::ST_IDLE: begin
        if (start) begin
          half_nxt  = item.brake_raw[15:1];
          now_nxt   = item.now_ms;
          dev_nxt   = dev_in;
          state_nxt = rbm_pkg::ST_MUL_SQ;
        end
      end
      rbm_pkg::ST_MUL_SQ: begin
        mul_en    = 1'b1;
        mul_a     = {9'd0, half_r};
        mul_b     = {9'd0, half_r};
        state_nxt = rbm_pkg::ST_DIV_SQ;
      end
      rbm_pkg::ST_DIV_SQ: begin
        sq_nxt    = rbm_pkg::div_neutral(prod[30:0]);
        state_nxt = rbm_pkg::ST_MUL_BS;
      end
      rbm_pkg::ST_MUL_BS: begin
        mul_en    = 1'b1;
        mul_a     = {7'd0, sq_r};
        mul_b     = {17'd0, cfg.brake_scale_pct};
        state_nxt = rbm_pkg::ST_REC_BS;
      end
      rbm_pkg::ST_REC_BS: begin
        mul_en    = 1'b1;
        mul_a     = {1'b0, prod[22:0]};
        mul_b     = rbm_pkg::RECIP_100;
        state_nxt = rbm_pkg::ST_MUL_DV;
      end
      rbm_pkg::ST_MUL_DV: begin
        sb_nxt    = prod[45:30];
        mul_en    = 1'b1;
        mul_a     = {8'd0, dev_r};
        mul_b     = {16'd0, cfg.rev_brake_scale_pct};
        state_nxt = rbm_pkg::ST_REC_DV;
      end
      rbm_pkg::ST_REC_DV: begin
        mul_en    = 1'b1;
        mul_a     = {1'b0, prod[22:0]};
        mul_b     = rbm_pkg::RECIP_100;
        state_nxt = rbm_pkg::ST_REV;
      end
      rbm_pkg::ST_REV: begin
        rev_nxt   = (rev_q > {2'b00, rbm_pkg::NEUTRAL}) ? rbm_pkg::NEUTRAL : rev_q[14:0];
        state_nxt = rbm_pkg::ST_MERGE;
      end
      rbm_pkg::ST_MERGE: begin
        if (rev_end) begin
          deadline_nxt = now_r + {16'd0, cfg.reverse_hold_ms};
          rev_act_nxt  = 1'b0;
        end
        if (rev_r > cfg.rev_brake_dead_band) begin
          rev_act_nxt = 1'b1;
        end
        fin_nxt   = (top_src > {1'b0, cfg.max_brake}) ? cfg.max_brake : top_src[14:0];
        state_nxt = rbm_pkg::ST_HOLD;
      end
      rbm_pkg::ST_HOLD: begin
        if (now_r < deadline_r) begin
          fin_nxt = cfg.max_brake;
        end
        state_nxt = rbm_pkg::ST_MUL_ST;
      end
      rbm_pkg::ST_MUL_ST: begin
        mul_en    = 1'b1;
        mul_a     = {8'd0, cfg.max_brake_step};
        mul_b     = {9'd0, fin_r};
        state_nxt = rbm_pkg::ST_DONE;
      end
      rbm_pkg::ST_DONE: begin
        if (res_take) begin
          state_nxt = rbm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rbm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rbm_pkg::ST_IDLE;
      rev_act_r  <= 1'b0;
      deadline_r <= 32'd0;
    end else begin
      state_r    <= state_nxt;
      rev_act_r  <= rev_act_nxt;
      deadline_r <= deadline_nxt;
    end
  end

  always_ff @(posedge clk) begin
    half_r <= half_nxt;
    now_r  <= now_nxt;
    dev_r  <= dev_nxt;
    sq_r   <= sq_nxt;
    sb_r   <= sb_nxt;
    rev_r  <= rev_nxt;
    fin_r  <= fin_nxt;
  end

  always_comb begin
    res.brake_out        = fin_r;
    res.ramp_brake_steps = 16'd0;
    res.steps_valid      = cfg.ramp_link_enable;
    if (cfg.ramp_link_enable) begin
      res.ramp_brake_steps = steps_q[16] ? 16'hFFFF : steps_q[15:0];
    end
  end

  assign idle      = (state_r == rbm_pkg::ST_IDLE);
  assign res_valid = (state_r == rbm_pkg::ST_DONE);

endmodule

FILE: hdl/rc_brake_merger.sv
// ----------------------------------------------------------------------------
// rc_brake_merger: brake command merger, top level
// Inputs are accepted only while the sequencer is idle, so one transaction is in
// the sequencer at a time as it steps through the single shared multiplier.
// The result register frees the core once filled, so a waiting result does
// not stall the next input. Reset is synchronous, active low, and restores
// the register defaults and clears the reverse-hold state.
// ----------------------------------------------------------------------------
module rc_brake_merger (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rbm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rbm_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  rbm_pkg::cfg_regs_t cfg;
  rbm_pkg::out_item_t res;
  rbm_pkg::out_item_t out_data_r;
  logic               out_valid_r, out_valid_nxt;
  logic               seq_idle;
  logic               res_valid;
  logic               res_take;

  assign cfg_ready = 1'b1;

  rbm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  rbm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .start     (in_valid && seq_idle),
    .item      (in_data),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign in_ready = seq_idle;
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: dv/rc_brake_merger_test.sv
// ----------------------------------------------------------------------------
// rc_brake_merger_test: self-checking testbench for the brake merger
// Drives control ticks and register writes through valid/ready channels with
// random idle bursts on both sides, predicts every brake command and step
// value, and compares each output transaction field by field in order.
// ----------------------------------------------------------------------------
module rc_brake_merger_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  REG_SPARE = 3'd7;
  localparam logic [15:0] MID       = 16'd32767;

  class brake_scoreboard;
    rbm_pkg::cfg_regs_t  regs;
    bit                  rev_on;
    bit [31:0]           hold_until;
    rbm_pkg::out_item_t  cmds_due[$];
    int                  n_checked;
    int                  n_errors;
    int                  n_hold;
    int                  n_reverse;
    int                  n_linked;

    function new();
      regs.rev_brake_scale_pct = 8'd100;
      regs.reverse_hold_ms     = 16'd500;
      regs.rev_brake_dead_band = 15'd0;
      regs.max_brake           = 15'd32767;
      regs.brake_scale_pct     = 7'd100;
      regs.max_brake_step      = 16'd0;
      regs.ramp_link_enable    = 1'b0;
      rev_on     = 1'b0;
      hold_until = '0;
      n_checked  = 0;
      n_errors   = 0;
      n_hold     = 0;
      n_reverse  = 0;
      n_linked   = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        rbm_pkg::REG_REV_PCT:   regs.rev_brake_scale_pct = d[7:0];
        rbm_pkg::REG_HOLD_MS:   regs.reverse_hold_ms     = d;
        rbm_pkg::REG_DEAD_BAND: regs.rev_brake_dead_band = d[14:0];
        rbm_pkg::REG_MAX_BRAKE: regs.max_brake           = d[14:0];
        rbm_pkg::REG_BRK_PCT:   regs.brake_scale_pct     = d[6:0];
        rbm_pkg::REG_MAX_STEP:  regs.max_brake_step      = d;
        rbm_pkg::REG_LINK_EN:   regs.ramp_link_enable    = d[0];
        default: ;
      endcase
    endfunction

    function rbm_pkg::out_item_t merge_brake(rbm_pkg::in_item_t it);
      longint unsigned half;
      longint unsigned squared;
      longint unsigned pedal;
      longint unsigned dev;
      longint unsigned opposing;
      longint unsigned hold;
      longint unsigned cmd;
      longint unsigned steps;
      rbm_pkg::out_item_t r;
      half = it.brake_raw >> 1;
      squared = half * half / rbm_pkg::NEUTRAL;
      pedal = squared * regs.brake_scale_pct / 100;
      dev = 0;
      if (it.ramp_value > rbm_pkg::NEUTRAL && it.stick_value < rbm_pkg::NEUTRAL) begin
        dev = rbm_pkg::NEUTRAL - it.stick_value;
      end else if (it.ramp_value < rbm_pkg::NEUTRAL &&
                   it.stick_value > rbm_pkg::NEUTRAL) begin
        dev = it.stick_value - rbm_pkg::NEUTRAL;
      end
      opposing = dev * regs.rev_brake_scale_pct / 100;
      if (opposing > rbm_pkg::NEUTRAL) begin
        opposing = rbm_pkg::NEUTRAL;
      end
      if (rev_on && opposing == 0) begin
        hold_until = it.now_ms + regs.reverse_hold_ms;
        rev_on = 1'b0;
      end
      if (opposing > regs.rev_brake_dead_band) begin
        rev_on = 1'b1;
      end
      hold = (it.now_ms < hold_until) ? regs.max_brake : 0;
      if (it.now_ms < hold_until) n_hold++;
      if (opposing != 0) n_reverse++;
      cmd = opposing;
      if (pedal > cmd) cmd = pedal;
      if (hold > cmd) cmd = hold;
      if (cmd > regs.max_brake) cmd = regs.max_brake;
      steps = 0;
      if (regs.ramp_link_enable) begin
        n_linked++;
        steps = regs.max_brake_step * cmd / rbm_pkg::NEUTRAL;
        if (steps > 16'hFFFF) steps = 16'hFFFF;
      end
      r.brake_out        = cmd[14:0];
      r.ramp_brake_steps = steps[15:0];
      r.steps_valid      = regs.ramp_link_enable;
      return r;
    endfunction

    function void note_input(rbm_pkg::in_item_t it);
      cmds_due.push_back(merge_brake(it));
    endfunction

    function void check_result(rbm_pkg::out_item_t got);
      rbm_pkg::out_item_t want;
      n_checked++;
      if (cmds_due.size() == 0) begin
        $display("%0t: unexpected result, brake_out %0d steps %0d valid %0d", $time,
                 got.brake_out, got.ramp_brake_steps, got.steps_valid);
        n_errors++;
        return;
      end
      want = cmds_due.pop_front();
      if (got.brake_out !== want.brake_out) begin
        $display("%0t: brake_out expected %0d actual %0d", $time,
                 want.brake_out, got.brake_out);
        n_errors++;
      end
      if (got.ramp_brake_steps !== want.ramp_brake_steps) begin
        $display("%0t: ramp_brake_steps expected %0d actual %0d", $time,
                 want.ramp_brake_steps, got.ramp_brake_steps);
        n_errors++;
      end
      if (got.steps_valid !== want.steps_valid) begin
        $display("%0t: steps_valid expected %0d actual %0d", $time,
                 want.steps_valid, got.steps_valid);
        n_errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  rbm_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  rbm_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  brake_scoreboard board = new();
  bit        quiet = 1'b0;
  int        n_sent = 0;
  int        n_settings = 0;
  bit [31:0] tick_ms = 32'd0;
  bit        dir_fwd = 1'b1;
  int        opp_left = 0;

  rc_brake_merger uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) board.note_input(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      out_ready <= (stall_left == 0);
    end
  end

  task automatic send_item(rbm_pkg::in_item_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic send_fields(bit [15:0] brake, bit [15:0] ramp, bit [15:0] stick,
                             bit [31:0] now);
    rbm_pkg::in_item_t it;
    it.brake_raw   = brake;
    it.ramp_value  = ramp;
    it.stick_value = stick;
    it.now_ms      = now;
    send_item(it);
  endtask

  task automatic wait_done();
    in_valid <= 1'b0;
    while (board.n_checked < n_sent) @(posedge clk);
  endtask

  task automatic cfg_put(logic [2:0] idx, bit [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic bit [15:0] with_junk(bit [15:0] v, int w);
    bit [15:0] keep;
    keep = 16'hFFFF >> (16 - w);
    return (16'($urandom) & ~keep) | (v & keep);
  endfunction

  task automatic apply_regs(rbm_pkg::cfg_regs_t c);
    cfg_put(rbm_pkg::REG_REV_PCT,   with_junk(16'(c.rev_brake_scale_pct), 8));
    cfg_put(rbm_pkg::REG_HOLD_MS,   c.reverse_hold_ms);
    cfg_put(rbm_pkg::REG_DEAD_BAND, with_junk(16'(c.rev_brake_dead_band), 15));
    cfg_put(rbm_pkg::REG_MAX_BRAKE, with_junk(16'(c.max_brake), 15));
    cfg_put(rbm_pkg::REG_BRK_PCT,   with_junk(16'(c.brake_scale_pct), 7));
    cfg_put(rbm_pkg::REG_MAX_STEP,  c.max_brake_step);
    cfg_put(rbm_pkg::REG_LINK_EN,   with_junk(16'(c.ramp_link_enable), 1));
    cfg_put(REG_SPARE,              16'($urandom));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic rbm_pkg::cfg_regs_t make_regs(int rev, int hold, int band, int cap,
                                                   int brk, int step, int link);
    rbm_pkg::cfg_regs_t c;
    c.rev_brake_scale_pct = 8'(rev);
    c.reverse_hold_ms     = 16'(hold);
    c.rev_brake_dead_band = 15'(band);
    c.max_brake           = 15'(cap);
    c.brake_scale_pct     = 7'(brk);
    c.max_brake_step      = 16'(step);
    c.ramp_link_enable    = 1'(link);
    return c;
  endfunction

  function automatic rbm_pkg::cfg_regs_t pick_regs();
    rbm_pkg::cfg_regs_t c;
    case ($urandom_range(0, 5))
      0: c.rev_brake_scale_pct = 8'd0;
      1: c.rev_brake_scale_pct = 8'd200;
      2: c.rev_brake_scale_pct = 8'($urandom_range(201, 255));
      default: c.rev_brake_scale_pct = 8'($urandom_range(0, 200));
    endcase
    case ($urandom_range(0, 7))
      0: c.reverse_hold_ms = 16'd0;
      1: c.reverse_hold_ms = 16'hFFFF;
      2: c.reverse_hold_ms = 16'($urandom_range(300, 3000));
      default: c.reverse_hold_ms = 16'($urandom_range(1, 300));
    endcase
    case ($urandom_range(0, 5))
      0: c.rev_brake_dead_band = 15'd0;
      1: c.rev_brake_dead_band = 15'h7FFF;
      2: c.rev_brake_dead_band = 15'($urandom);
      default: c.rev_brake_dead_band = 15'($urandom_range(0, 3000));
    endcase
    case ($urandom_range(0, 4))
      0: c.max_brake = 15'd0;
      1: c.max_brake = 15'h7FFF;
      default: c.max_brake = 15'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: c.brake_scale_pct = 7'd0;
      1: c.brake_scale_pct = 7'd100;
      2: c.brake_scale_pct = 7'($urandom_range(101, 127));
      default: c.brake_scale_pct = 7'($urandom_range(0, 100));
    endcase
    case ($urandom_range(0, 4))
      0: c.max_brake_step = 16'd0;
      1: c.max_brake_step = 16'hFFFF;
      default: c.max_brake_step = 16'($urandom);
    endcase
    c.ramp_link_enable = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Reverse episodes hold the stick against the direction of travel for a few
  // ticks, then release it so that the hold window follows.
  task automatic send_random();
    rbm_pkg::in_item_t it;
    int                k;
    int unsigned       d;
    k = $urandom_range(0, 99);
    if (k < 75) begin
      tick_ms += $urandom_range(0, 40);
    end else if (k < 93) begin
      tick_ms += $urandom_range(40, 1500);
    end else if (k < 97) begin
      tick_ms = $urandom;
    end else begin
      tick_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
    end
    if ($urandom_range(0, 15) == 0) dir_fwd = !dir_fwd;
    k = $urandom_range(0, 19);
    if (k == 0) begin
      it.ramp_value = MID;
    end else if (k == 1) begin
      it.ramp_value = 16'($urandom);
    end else if (dir_fwd) begin
      it.ramp_value = 16'($urandom_range(32768, 65535));
    end else begin
      it.ramp_value = 16'($urandom_range(0, 32766));
    end
    if (opp_left == 0 && $urandom_range(0, 7) == 0) begin
      opp_left = $urandom_range(1, 8);
    end
    if (opp_left > 0) begin
      opp_left--;
      d = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3000) : $urandom_range(1, 32767);
      if (dir_fwd) begin
        it.stick_value = 16'(32767 - d);
      end else begin
        it.stick_value = 16'(32767 + d + $urandom_range(0, 1));
      end
    end else begin
      k = $urandom_range(0, 9);
      if (k < 5) begin
        it.stick_value = MID;
      end else if (k < 8) begin
        it.stick_value = dir_fwd ? 16'($urandom_range(32768, 65535))
                                 : 16'($urandom_range(0, 32766));
      end else begin
        it.stick_value = 16'($urandom);
      end
    end
    k = $urandom_range(0, 19);
    if (k < 9) begin
      it.brake_raw = 16'd0;
    end else if (k < 14) begin
      it.brake_raw = 16'($urandom);
    end else if (k < 17) begin
      it.brake_raw = 16'($urandom_range(16'hF000, 16'hFFFF));
    end else begin
      it.brake_raw = 16'($urandom_range(0, 16'h2000));
    end
    it.now_ms = tick_ms;
    send_item(it);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values: neutral, full pedal, reverse brake and its hold.
    send_fields(16'h0000, MID, MID, 32'd0);
    send_fields(16'hFFFF, MID, MID, 32'd1);
    send_fields(16'h0001, 16'hFFFF, 16'hFFFF, 32'd2);
    send_fields(16'h0000, 16'hFFFF, 16'h0000, 32'd10);
    send_fields(16'h0000, 16'h0000, 16'hFFFF, 32'd20);
    send_fields(16'h0000, 16'hFFFF, MID, 32'd30);
    send_fields(16'h8000, MID, 16'h0000, 32'd40);
    send_fields(16'h0000, 16'h8000, 16'h7FFE, 32'd529);
    send_fields(16'h0000, 16'h8000, MID, 32'd530);
    send_fields(16'h0000, MID, MID, 32'd1030);
    send_fields(16'h0000, 16'hFFFF, 16'h0000, 32'hFFFF_FF00);
    send_fields(16'h0000, 16'hFFFF, MID, 32'hFFFF_FFF0);
    send_fields(16'hFFFE, MID, MID, 32'h0000_0010);
    wait_done();

    // Registers above their range and at their limits.
    apply_regs(make_regs(255, 65535, 32767, 32767, 127, 65535, 1));
    send_fields(16'hFFFF, MID, MID, 32'd5000);
    send_fields(16'h0000, 16'hFFFF, 16'h0000, 32'd5001);
    send_fields(16'h5555, 16'h0000, 16'hAAAA, 32'h8000_0000);
    send_fields(16'hAAAA, 16'h0001, 16'hFFFE, 32'h7FFF_FFFF);
    wait_done();

    apply_regs(make_regs(100, 100, 1000, 20000, 50, 40000, 1));
    send_fields(16'h0000, 16'hC000, 16'd32267, 32'd6000);
    send_fields(16'h0000, 16'hC000, 16'd30767, 32'd6010);
    send_fields(16'h4000, 16'hC000, MID, 32'd6020);
    wait_done();

    apply_regs(make_regs(0, 0, 0, 0, 0, 0, 0));
    send_fields(16'hFFFF, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    send_fields(16'hFFFF, 16'h0000, 16'hFFFF, 32'd0);
    wait_done();

    for (int p = 0; p < 8; p++) begin
      quiet = (p == 3) || (p == 7);
      apply_regs(pick_regs());
      for (int i = 0; i < 131; i++) send_random();
      wait_done();
    end

    repeat (24) @(posedge clk);
    if (board.cmds_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, board.cmds_due.size());
      board.n_errors++;
    end
    $display("summary: %0d ticks checked over %0d register settings",
             board.n_checked, n_settings);
    $display("summary: %0d in reverse hold, %0d with reverse brake, %0d with steps linked",
             board.n_hold, board.n_reverse, board.n_linked);
    if (board.n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: rc_brake_merger.f
hdl/rbm_pkg.sv
hdl/rbm_cfg_regs.sv
hdl/rbm_mul_unit.sv
hdl/rbm_seq.sv
hdl/rc_brake_merger.sv
dv/rc_brake_merger_test.sv
